>>> rtl/spd_pkg.sv
// shared types and constants for the sequential prefetch detector
// no dependencies
package spd_pkg;

    localparam logic [1:0] FUNC_RECORD = 2'd0;
    localparam logic [1:0] FUNC_QUERY  = 2'd1;
    localparam logic [1:0] FUNC_CLEAR  = 2'd2;

    localparam logic [1:0] MODE_NONE       = 2'd0;
    localparam logic [1:0] MODE_SEQUENTIAL = 2'd1;
    localparam logic [1:0] MODE_ADAPTIVE   = 2'd2;
    localparam logic [1:0] MODE_RANDOM     = 2'd3;

    localparam logic [1:0] REG_STRATEGY_MODE  = 2'd0;
    localparam logic [1:0] REG_WINDOW_LENGTH  = 2'd1;
    localparam logic [1:0] REG_AGGRESSIVENESS = 2'd2;

    localparam logic [1:0] RESET_STRATEGY_MODE  = 2'd1;
    localparam logic [4:0] RESET_WINDOW_LENGTH  = 5'd4;
    localparam logic [8:0] RESET_AGGRESSIVENESS = 9'd128;

    localparam int CFG_W = 9;

    typedef struct packed {
        logic [1:0]         func;
        logic [2:0]         table_index;
        logic signed [31:0] page_number;
    } item_t;

    typedef struct packed {
        logic       do_prefetch;
        logic [4:0] entries_examined;
        logic [4:0] sequential_pairs;
    } result_t;

    typedef struct packed {
        logic record;
        logic clear;
    } ctx_cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_WALK,
        ST_DECIDE
    } state_t;

endpackage

>>> rtl/sequential_prefetch_detector_core.sv
// top level of the sequential prefetch detector: sequencer, compare walk and config registers
// depends on spd_pkg, spd_ram, spd_ctx, spd_decide
//
// An item is taken when start is high and busy is low. Record and clear items keep busy high for
// one cycle and give no result. A query of n = min(window_length, fill) entries keeps busy high
// through the exec, walk (skipped when n is zero) and decide states; the walk reads one history
// entry per cycle through the single read port of the history ram and checks one pair per cycle;
// done marks its result for one cycle, the first in which busy is low again. The result cannot
// be held off, so it must be taken when done is high. No clearing pass is needed after reset.
module sequential_prefetch_detector_core #(
    parameter int HISTORY_DEPTH = 20,
    parameter int NUM_TABLES    = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  spd_pkg::item_t                item,
    output logic                          done,
    output spd_pkg::result_t              result,
    input  logic                          cfg_we,
    input  logic [1:0]                    cfg_index,
    input  logic [spd_pkg::CFG_W-1:0]     cfg_data
);

    localparam int TBL_W  = (NUM_TABLES > 1) ? $clog2(NUM_TABLES) : 1;
    localparam int PTR_W  = $clog2(HISTORY_DEPTH);
    localparam int FILL_W = $clog2(HISTORY_DEPTH + 1);
    localparam int DEPTH  = NUM_TABLES * HISTORY_DEPTH;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    spd_pkg::state_t   state_reg, state_next;
    spd_pkg::item_t    item_reg, item_next;
    logic [4:0]        n_reg, n_next;
    logic [PTR_W-1:0]  ptr_reg, ptr_next;
    logic [4:0]        issued_reg, issued_next;
    logic [4:0]        recv_reg, recv_next;
    logic              rd_valid_reg, rd_valid_next;
    logic [31:0]       prev_reg, prev_next;
    logic [4:0]        pairs_reg, pairs_next;

    logic [1:0]        mode_reg;
    logic [4:0]        win_reg;
    logic [8:0]        aggr_reg;

    logic              tbl_ok;
    logic [TBL_W-1:0]  tbl_sel;
    logic [ADDR_W-1:0] base;
    logic [FILL_W-1:0] fill;
    logic [PTR_W-1:0]  wp;
    logic [4:0]        n_calc;
    logic [31:0]       start_sum;
    logic [PTR_W-1:0]  start_ptr;
    logic [PTR_W-1:0]  ptr_inc;
    logic              issue;

    spd_pkg::ctx_cmd_t cmd;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [ADDR_W-1:0] ram_raddr;
    logic [31:0]       ram_rdata;
    logic              dec_go;

    assign tbl_ok    = 32'(item_reg.table_index) < 32'(NUM_TABLES);
    assign tbl_sel   = TBL_W'(item_reg.table_index);
    assign base      = ADDR_W'(32'(tbl_sel) * 32'(HISTORY_DEPTH));
    assign ram_waddr = base + ADDR_W'(wp);
    assign ram_raddr = base + ADDR_W'(ptr_reg);
    assign busy      = (state_reg != spd_pkg::ST_IDLE);

    spd_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_hist (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (item_reg.page_number),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    spd_ctx #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .NUM_TABLES    (NUM_TABLES)
    ) u_ctx (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .sel   (tbl_sel),
        .fill  (fill),
        .wp    (wp)
    );

    spd_decide u_decide (
        .clk    (clk),
        .rst_n  (rst_n),
        .go     (dec_go),
        .mode   (mode_reg),
        .aggr   (aggr_reg),
        .n      (n_reg),
        .pairs  (pairs_reg),
        .done   (done),
        .result (result)
    );

    // window start and ring increment
    always_comb
    begin
        if (!tbl_ok)
        begin
            n_calc = '0;
        end
        else if (32'(win_reg) < 32'(fill))
        begin
            n_calc = win_reg;
        end
        else
        begin
            n_calc = 5'(fill);
        end
        start_sum = 32'(wp) + 32'(HISTORY_DEPTH) - 32'(n_calc);
        if (start_sum >= 32'(HISTORY_DEPTH))
        begin
            start_ptr = PTR_W'(start_sum - 32'(HISTORY_DEPTH));
        end
        else
        begin
            start_ptr = PTR_W'(start_sum);
        end
        ptr_inc = (32'(ptr_reg) + 32'd1 == 32'(HISTORY_DEPTH)) ? '0 : ptr_reg + PTR_W'(1);
        issue   = issued_reg < n_reg;
    end

    always_comb
    begin
        state_next    = state_reg;
        item_next     = item_reg;
        n_next        = n_reg;
        ptr_next      = ptr_reg;
        issued_next   = issued_reg;
        recv_next     = recv_reg;
        rd_valid_next = 1'b0;
        prev_next     = prev_reg;
        pairs_next    = pairs_reg;
        cmd           = '0;
        ram_we        = 1'b0;
        dec_go        = 1'b0;
        unique case (state_reg)
            spd_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    item_next  = item;
                    state_next = spd_pkg::ST_EXEC;
                end
            end
            spd_pkg::ST_EXEC:
            begin
                state_next = spd_pkg::ST_IDLE;
                unique case (item_reg.func)
                    spd_pkg::FUNC_RECORD:
                    begin
                        ram_we     = tbl_ok;
                        cmd.record = tbl_ok;
                    end
                    spd_pkg::FUNC_CLEAR:
                    begin
                        cmd.clear = tbl_ok;
                    end
                    spd_pkg::FUNC_QUERY:
                    begin
                        n_next      = n_calc;
                        ptr_next    = start_ptr;
                        issued_next = '0;
                        recv_next   = '0;
                        pairs_next  = '0;
                        state_next  = (n_calc == 5'd0) ? spd_pkg::ST_DECIDE : spd_pkg::ST_WALK;
                    end
                    default:
                    begin
                        state_next = spd_pkg::ST_IDLE;
                    end
                endcase
            end
            spd_pkg::ST_WALK:
            begin
                rd_valid_next = issue;
                if (issue)
                begin
                    ptr_next    = ptr_inc;
                    issued_next = issued_reg + 5'd1;
                end
                if (rd_valid_reg)
                begin
                    prev_next = ram_rdata;
                    recv_next = recv_reg + 5'd1;
                    if ((recv_reg != 5'd0) && (ram_rdata == prev_reg + 32'd1))
                    begin
                        pairs_next = pairs_reg + 5'd1;
                    end
                end
                if (recv_next == n_reg)
                begin
                    state_next = spd_pkg::ST_DECIDE;
                end
            end
            spd_pkg::ST_DECIDE:
            begin
                dec_go     = 1'b1;
                state_next = spd_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = spd_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= spd_pkg::ST_IDLE;
            rd_valid_reg <= 1'b0;
            issued_reg   <= '0;
            recv_reg     <= '0;
            n_reg        <= '0;
            pairs_reg    <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            rd_valid_reg <= rd_valid_next;
            issued_reg   <= issued_next;
            recv_reg     <= recv_next;
            n_reg        <= n_next;
            pairs_reg    <= pairs_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        ptr_reg  <= ptr_next;
        prev_reg <= prev_next;
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= spd_pkg::RESET_STRATEGY_MODE;
            win_reg  <= spd_pkg::RESET_WINDOW_LENGTH;
            aggr_reg <= spd_pkg::RESET_AGGRESSIVENESS;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                spd_pkg::REG_STRATEGY_MODE:  mode_reg <= cfg_data[1:0];
                spd_pkg::REG_WINDOW_LENGTH:  win_reg  <= cfg_data[4:0];
                spd_pkg::REG_AGGRESSIVENESS: aggr_reg <= cfg_data[8:0];
                default:                     mode_reg <= mode_reg;
            endcase
        end
    end

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result transfer while busy");

    a_decide_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == spd_pkg::ST_DECIDE) |=> done)
        else $error("decision not followed by result");

    a_pairs_bound: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.sequential_pairs == 5'd0 ||
                  result.sequential_pairs < result.entries_examined))
        else $error("pair count exceeds window");

    a_walk_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == spd_pkg::ST_WALK) |-> (recv_reg <= issued_reg && issued_reg <= n_reg))
        else $error("walk counters out of order");

    a_none_mode: assert property (@(posedge clk) disable iff (!rst_n)
        done && ($past(mode_reg) == spd_pkg::MODE_NONE) |-> !result.do_prefetch)
        else $error("prefetch issued with strategy none");

endmodule

>>> rtl/spd_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
module spd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 160
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/spd_ctx.sv
// per-table fill count and write pointer registers
// depends on spd_pkg
module spd_ctx #(
    parameter int HISTORY_DEPTH = 20,
    parameter int NUM_TABLES    = 8
) (
    input  logic                                             clk,
    input  logic                                             rst_n,
    input  spd_pkg::ctx_cmd_t                                cmd,
    input  logic [(NUM_TABLES > 1 ? $clog2(NUM_TABLES) : 1)-1:0] sel,
    output logic [$clog2(HISTORY_DEPTH+1)-1:0]              fill,
    output logic [$clog2(HISTORY_DEPTH)-1:0]                wp
);

    localparam int PTR_W  = $clog2(HISTORY_DEPTH);
    localparam int FILL_W = $clog2(HISTORY_DEPTH + 1);

    logic [FILL_W-1:0] fill_reg [NUM_TABLES];
    logic [PTR_W-1:0]  wp_reg   [NUM_TABLES];
    logic [PTR_W-1:0]  wp_inc;
    logic [FILL_W-1:0] fill_inc;

    assign fill = fill_reg[sel];
    assign wp   = wp_reg[sel];

    always_comb
    begin
        wp_inc = (32'(wp) + 32'd1 == 32'(HISTORY_DEPTH)) ? '0 : wp + PTR_W'(1);
        fill_inc = (32'(fill) < 32'(HISTORY_DEPTH)) ? fill + FILL_W'(1) : fill;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int t = 0; t < NUM_TABLES; t++)
            begin
                fill_reg[t] <= '0;
                wp_reg[t]   <= '0;
            end
        end
        else if (cmd.clear)
        begin
            fill_reg[sel] <= '0;
            wp_reg[sel]   <= '0;
        end
        else if (cmd.record)
        begin
            fill_reg[sel] <= fill_inc;
            wp_reg[sel]   <= wp_inc;
        end
    end

endmodule

>>> rtl/spd_decide.sv
// prefetch decision stage, registers the result and its strobe
// depends on spd_pkg
module spd_decide (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             go,
    input  logic [1:0]       mode,
    input  logic [8:0]       aggr,
    input  logic [4:0]       n,
    input  logic [4:0]       pairs,
    output logic             done,
    output spd_pkg::result_t result
);

    logic             done_reg;
    spd_pkg::result_t result_reg;
    logic             decide;
    logic [4:0]       n_m1;
    logic [8:0]       seq_lhs;
    logic [8:0]       seq_rhs;
    logic [13:0]      ada_lhs;
    logic [13:0]      ada_rhs;

    always_comb
    begin
        n_m1    = n - 5'd1;
        seq_lhs = 9'(pairs) * 9'd10;
        seq_rhs = 9'(n_m1) * 9'd7;
        ada_lhs = {1'b0, pairs, 8'd0};
        ada_rhs = 14'(aggr) * 14'(n_m1);
        unique case (mode)
            spd_pkg::MODE_SEQUENTIAL: decide = (n >= 5'd3) && (seq_lhs > seq_rhs);
            spd_pkg::MODE_ADAPTIVE:   decide = (n >= 5'd2) && (ada_lhs > ada_rhs);
            spd_pkg::MODE_RANDOM:     decide = 1'b1;
            default:                  decide = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= go;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            result_reg.do_prefetch      <= decide;
            result_reg.entries_examined <= n;
            result_reg.sequential_pairs <= pairs;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// testbench for sequential_prefetch_detector_core: directed and random record, query and clear
// transfers, each query result checked against an in-bench copy of the page histories
// depends on spd_pkg and the rtl of sequential_prefetch_detector_core
module tb_top;

    localparam int DEPTH = 20;
    localparam int TABLES = 8;
    localparam int DRAIN_CYCLES = 32;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int EXP_DEPTH = 64;
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    spd_pkg::item_t item = '0;
    logic done;
    spd_pkg::result_t result;
    logic cfg_we = 1'b0;
    logic [1:0] cfg_index = spd_pkg::REG_STRATEGY_MODE;
    logic [spd_pkg::CFG_W-1:0] cfg_data = '0;

    // page histories and register copies
    logic [31:0] page_history [TABLES][DEPTH];
    int unsigned history_fill [TABLES];
    int unsigned history_wp [TABLES];
    logic [31:0] stream_next [TABLES];
    logic [1:0] mode_reg = spd_pkg::RESET_STRATEGY_MODE;
    logic [4:0] window_reg = spd_pkg::RESET_WINDOW_LENGTH;
    logic [8:0] aggr_reg = spd_pkg::RESET_AGGRESSIVENESS;

    // expected results in order, written and read by running counts
    spd_pkg::result_t expected_decisions [EXP_DEPTH];
    int exp_wr = 0;
    int exp_rd = 0;
    int mismatch_count = 0;
    int sender_idle_pct = 0;
    int quiet_cycles = 0;

    sequential_prefetch_detector_core #(
        .HISTORY_DEPTH(DEPTH),
        .NUM_TABLES(TABLES)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .item(item),
        .done(done),
        .result(result),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #1 clk = ~clk;

    function automatic spd_pkg::result_t predict_decision(int unsigned tbl);
        spd_pkg::result_t r;
        int unsigned n;
        int unsigned pairs;
        int unsigned first;
        int unsigned i;
        n = (window_reg < history_fill[tbl]) ? window_reg : history_fill[tbl];
        first = (history_wp[tbl] + DEPTH - n) % DEPTH;
        pairs = 0;
        for (i = 1; i < n; i++)
        begin
            if (page_history[tbl][(first + i) % DEPTH] ==
                page_history[tbl][(first + i - 1) % DEPTH] + 32'd1)
                pairs++;
        end
        case (mode_reg)
            spd_pkg::MODE_SEQUENTIAL:
                r.do_prefetch = (n >= 3) && (pairs * 10 > 7 * (n - 1));
            spd_pkg::MODE_ADAPTIVE:
                r.do_prefetch = (n >= 2) && (pairs * 256 > aggr_reg * (n - 1));
            spd_pkg::MODE_RANDOM:
                r.do_prefetch = 1'b1;
            default:
                r.do_prefetch = 1'b0;
        endcase
        r.entries_examined = 5'(n);
        r.sequential_pairs = 5'(pairs);
        return r;
    endfunction

    function automatic void advance_history(spd_pkg::item_t it);
        int unsigned tbl;
        tbl = it.table_index;
        case (it.func)
            spd_pkg::FUNC_RECORD:
            begin
                page_history[tbl][history_wp[tbl]] = it.page_number;
                history_wp[tbl] = (history_wp[tbl] + 1) % DEPTH;
                if (history_fill[tbl] < DEPTH)
                    history_fill[tbl]++;
            end
            spd_pkg::FUNC_QUERY:
            begin
                expected_decisions[exp_wr % EXP_DEPTH] = predict_decision(tbl);
                exp_wr++;
            end
            spd_pkg::FUNC_CLEAR:
            begin
                history_fill[tbl] = 0;
                history_wp[tbl] = 0;
            end
            default: ;
        endcase
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        mismatch_count++;
    endtask

    task automatic send_item(input logic [1:0] func, input int unsigned tbl,
                             input logic [31:0] page);
        spd_pkg::item_t it;
        it.func = func;
        it.table_index = tbl[2:0];
        it.page_number = page;
        while ($urandom_range(99) < sender_idle_pct)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
        @(negedge clk);
        start <= 1'b1;
        item <= it;
        do @(posedge clk); while (busy);
        advance_history(it);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        start <= 1'b0;
        while (exp_rd != exp_wr)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input int unsigned value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= spd_pkg::CFG_W'(value);
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            spd_pkg::REG_STRATEGY_MODE:  mode_reg = 2'(value);
            spd_pkg::REG_WINDOW_LENGTH:  window_reg = 5'(value);
            spd_pkg::REG_AGGRESSIVENESS: aggr_reg = 9'(value);
            default: ;
        endcase
    endtask

    task automatic set_config(input int unsigned mode, input int unsigned window,
                              input int unsigned aggr);
        wait_drained();
        write_reg(spd_pkg::REG_STRATEGY_MODE, mode);
        write_reg(spd_pkg::REG_WINDOW_LENGTH, window);
        write_reg(spd_pkg::REG_AGGRESSIVENESS, aggr);
    endtask

    // reset values, empty table, page wrap at the sign boundary and at all ones
    task automatic test_wrap_and_empty();
        send_item(spd_pkg::FUNC_QUERY, 0, 32'd0);
        send_item(spd_pkg::FUNC_RECORD, 7, 32'h7FFF_FFFE);
        send_item(spd_pkg::FUNC_RECORD, 7, 32'h7FFF_FFFF);
        send_item(spd_pkg::FUNC_RECORD, 7, 32'h8000_0000);
        send_item(spd_pkg::FUNC_RECORD, 7, 32'h8000_0001);
        send_item(spd_pkg::FUNC_QUERY, 7, 32'hFFFF_FFFF);
        send_item(spd_pkg::FUNC_RECORD, 3, 32'hFFFF_FFFF);
        send_item(spd_pkg::FUNC_RECORD, 3, 32'h0000_0000);
        send_item(spd_pkg::FUNC_QUERY, 3, 32'h5555_5555);
    endtask

    // unused function code is ignored, clear empties a table
    task automatic test_unused_and_clear();
        send_item(FUNC_UNUSED, 7, 32'hAAAA_AAAA);
        send_item(spd_pkg::FUNC_QUERY, 7, 32'd0);
        send_item(spd_pkg::FUNC_CLEAR, 7, 32'hFFFF_FFFF);
        send_item(spd_pkg::FUNC_QUERY, 7, 32'd0);
    endtask

    // each strategy, window above fill, zero window, oversize aggressiveness
    task automatic test_strategies();
        set_config(spd_pkg::MODE_NONE, 20, 128);
        send_item(spd_pkg::FUNC_RECORD, 1, 32'd5);
        send_item(spd_pkg::FUNC_RECORD, 1, 32'd6);
        send_item(spd_pkg::FUNC_RECORD, 1, 32'd7);
        send_item(spd_pkg::FUNC_RECORD, 1, 32'd9);
        send_item(spd_pkg::FUNC_RECORD, 1, 32'd10);
        send_item(spd_pkg::FUNC_QUERY, 1, 32'd0);
        set_config(spd_pkg::MODE_RANDOM, 20, 128);
        send_item(spd_pkg::FUNC_QUERY, 1, 32'd0);
        set_config(spd_pkg::MODE_ADAPTIVE, 20, 191);
        send_item(spd_pkg::FUNC_QUERY, 1, 32'd0);
        set_config(spd_pkg::MODE_ADAPTIVE, 20, 256);
        send_item(spd_pkg::FUNC_QUERY, 1, 32'd0);
        set_config(spd_pkg::MODE_ADAPTIVE, 20, 511);
        send_item(spd_pkg::FUNC_QUERY, 1, 32'd0);
        set_config(spd_pkg::MODE_RANDOM, 0, 0);
        send_item(spd_pkg::FUNC_QUERY, 1, 32'd0);
        set_config(spd_pkg::MODE_SEQUENTIAL, 31, 0);
        send_item(spd_pkg::FUNC_QUERY, 1, 32'd0);
    endtask

    // mostly ascending page streams per table with breaks, queries, clears and noise
    task automatic test_random_traffic(input int idle_pct, input int count);
        int sent;
        int unsigned roll;
        int unsigned tbl;
        int unsigned window;
        int unsigned aggr;
        logic [31:0] page;
        sender_idle_pct = idle_pct;
        sent = 0;
        while (sent < count)
        begin
            if (sent % 50 == 0)
            begin
                window = ($urandom_range(9) == 0) ? $urandom_range(31, 21) : $urandom_range(20);
                case ($urandom_range(5))
                    0: aggr = 0;
                    1: aggr = 256;
                    2: aggr = 179;
                    3: aggr = $urandom_range(511, 257);
                    default: aggr = $urandom_range(256);
                endcase
                set_config($urandom_range(3), window, aggr);
                sender_idle_pct = idle_pct;
            end
            roll = $urandom_range(99);
            tbl = $urandom_range(TABLES - 1);
            page = $urandom;
            if (roll < 58)
            begin
                case ($urandom_range(19))
                    0: page = 32'h7FFF_FFFF;
                    1: page = 32'hFFFF_FFFF;
                    2, 3, 4: ;
                    default: page = stream_next[tbl];
                endcase
                stream_next[tbl] = page + 32'd1;
                send_item(spd_pkg::FUNC_RECORD, tbl, page);
                sent++;
            end
            else if (roll < 94)
            begin
                send_item(spd_pkg::FUNC_QUERY, tbl, page);
                sent++;
            end
            else if (roll < 97)
            begin
                send_item(spd_pkg::FUNC_CLEAR, tbl, page);
                sent++;
            end
            else
                send_item(FUNC_UNUSED, tbl, page);
        end
    endtask

    always @(posedge clk)
    begin
        spd_pkg::result_t want;
        if (rst_n && done)
        begin
            if (exp_rd == exp_wr)
                report_mismatch("result with no query pending", 1, 0);
            else
            begin
                want = expected_decisions[exp_rd % EXP_DEPTH];
                exp_rd++;
                if (result.do_prefetch !== want.do_prefetch)
                    report_mismatch("do_prefetch", result.do_prefetch, want.do_prefetch);
                if (result.entries_examined !== want.entries_examined)
                    report_mismatch("entries_examined", result.entries_examined,
                                    want.entries_examined);
                if (result.sequential_pairs !== want.sequential_pairs)
                    report_mismatch("sequential_pairs", result.sequential_pairs,
                                    want.sequential_pairs);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        for (int t = 0; t < TABLES; t++)
        begin
            history_fill[t] = 0;
            history_wp[t] = 0;
            stream_next[t] = $urandom;
        end
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_wrap_and_empty();
        test_unused_and_clear();
        test_strategies();
        test_random_traffic(22, 200);
        test_random_traffic(72, 200);
        test_random_traffic(0, 200);
        wait_drained();

        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
